/* rtl/wmf_pkg.sv */
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared types and constants of the windowed mode filter.
// ----------------------------------------------------------------------------
package wmf_pkg;

    localparam int ROW_LIMIT  = 1024;
    localparam int ROW_W      = 10;
    localparam int DIM_W      = 11;
    localparam int HALF_W     = 2;
    localparam int CFG_DATA_W = 11;
    localparam int COLOR_W    = 32;

    typedef enum logic [1:0] {
        CFG_HALF_WINDOW_WIDTH  = 2'd0,
        CFG_HALF_WINDOW_HEIGHT = 2'd1,
        CFG_IMAGE_WIDTH        = 2'd2,
        CFG_IMAGE_HEIGHT       = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef struct packed {
        logic               op;
        logic [COLOR_W-1:0] pixel_color;
    } in_word_t;

    typedef struct packed {
        logic [COLOR_W-1:0] mode_color;
        logic               last_of_frame;
    } out_word_t;

    typedef struct packed {
        logic take;
        logic latch;
        logic write;
        logic win_init;
        logic load_issue;
        logic count_step;
        logic emit;
    } wmf_cmd_t;

    typedef struct packed {
        logic is_pixel;
        logic active;
        logic done;
        logic emit_due;
        logic load_last;
        logic count_last;
        logic out_free;
    } wmf_sts_t;

endpackage

/* rtl/wmf_ram.sv */
// ----------------------------------------------------------------------------
// wmf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module wmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/wmf_ctrl.sv */
// ----------------------------------------------------------------------------
// wmf_ctrl
// Sequencer: takes one word, writes pixels to the store, gathers the window, counts and emits.
// ----------------------------------------------------------------------------
module wmf_ctrl
    import wmf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  wmf_sts_t sts,
    output wmf_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_LATCH,
        S_WRITE,
        S_WIN_INIT,
        S_LOAD,
        S_LOAD_WAIT,
        S_COUNT
    } state_t;

    typedef enum logic {
        E_NONE,
        E_EMIT
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        if (phase_reg == E_EMIT)
        begin
            if (sts.out_free)
            begin
                cmd.emit   = 1'b1;
                phase_next = E_NONE;
                state_next = S_IDLE;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.take   = 1'b1;
                        state_next = S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    priority if (sts.is_pixel && !sts.done)
                        state_next = sts.active ? S_WRITE : S_LATCH;
                    else if (sts.active && sts.done)
                        state_next = S_WIN_INIT;
                    else
                        state_next = S_IDLE;
                end
                S_LATCH:
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_WRITE;
                end
                S_WRITE:
                begin
                    cmd.write  = 1'b1;
                    state_next = sts.emit_due ? S_WIN_INIT : S_IDLE;
                end
                S_WIN_INIT:
                begin
                    cmd.win_init = 1'b1;
                    state_next   = S_LOAD;
                end
                S_LOAD:
                begin
                    cmd.load_issue = 1'b1;
                    if (sts.load_last)
                        state_next = S_LOAD_WAIT;
                end
                S_LOAD_WAIT:
                begin
                    state_next = S_COUNT;
                end
                S_COUNT:
                begin
                    cmd.count_step = 1'b1;
                    if (sts.count_last)
                        phase_next = E_EMIT;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= E_NONE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

/* rtl/wmf_datapath.sv */
// ----------------------------------------------------------------------------
// wmf_datapath
// Geometry, raster counters, line store, window buffer and mode counter.
// ----------------------------------------------------------------------------
module wmf_datapath
    import wmf_pkg::*;
#(
    parameter int MAX_HALF_WINDOW = 3,
    parameter int MAX_IMAGE_WIDTH = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_data,
    input  wmf_cmd_t              cmd,
    output wmf_sts_t              sts
);

    localparam int SPAN    = 2 * MAX_HALF_WINDOW + 1;
    localparam int DEPTH   = SPAN * MAX_IMAGE_WIDTH;
    localparam int WIN     = SPAN * SPAN;
    localparam int AW      = $clog2(DEPTH);
    localparam int COL_W   = $clog2(MAX_IMAGE_WIDTH + 1);
    localparam int HW_W    = $clog2(MAX_HALF_WINDOW + 1);
    localparam int SPAN_W  = $clog2(SPAN + 1);
    localparam int WIN_IW  = $clog2(WIN);
    localparam int WIN_CW  = $clog2(WIN + 1);
    localparam int CNT_W   = $clog2(ROW_LIMIT * MAX_IMAGE_WIDTH);
    localparam int CMP_W   = (DIM_W > COL_W) ? DIM_W : COL_W;

    // configuration
    logic [HALF_W-1:0] hw_cfg_reg, hh_cfg_reg;
    logic [DIM_W-1:0]  w_cfg_reg, h_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_cfg_reg <= HALF_W'(1);
            hh_cfg_reg <= HALF_W'(1);
            w_cfg_reg  <= DIM_W'(640);
            h_cfg_reg  <= DIM_W'(480);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HALF_WINDOW_WIDTH:  hw_cfg_reg <= cfg_data[HALF_W-1:0];
                CFG_HALF_WINDOW_HEIGHT: hh_cfg_reg <= cfg_data[HALF_W-1:0];
                CFG_IMAGE_WIDTH:        w_cfg_reg  <= cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:       h_cfg_reg  <= cfg_data[DIM_W-1:0];
                default:                ;
            endcase
        end
    end

    // clamped geometry
    logic [COL_W-1:0] cl_w;
    logic [DIM_W-1:0] cl_h;
    logic [HW_W-1:0]  cl_hw, cl_hh;

    always_comb
    begin
        if (w_cfg_reg == '0)
            cl_w = COL_W'(1);
        else if (CMP_W'(w_cfg_reg) > CMP_W'(MAX_IMAGE_WIDTH))
            cl_w = COL_W'(MAX_IMAGE_WIDTH);
        else
            cl_w = COL_W'(w_cfg_reg);
        if (h_cfg_reg == '0)
            cl_h = DIM_W'(1);
        else if (h_cfg_reg > DIM_W'(ROW_LIMIT))
            cl_h = DIM_W'(ROW_LIMIT);
        else
            cl_h = h_cfg_reg;
        cl_hw = (int'(hw_cfg_reg) > MAX_HALF_WINDOW) ? HW_W'(MAX_HALF_WINDOW)
                                                     : HW_W'(hw_cfg_reg);
        cl_hh = (int'(hh_cfg_reg) > MAX_HALF_WINDOW) ? HW_W'(MAX_HALF_WINDOW)
                                                     : HW_W'(hh_cfg_reg);
    end

    logic [COL_W-1:0] g_w_reg;
    logic [DIM_W-1:0] g_h_reg;
    logic [HW_W-1:0]  g_hw_reg, g_hh_reg;
    logic [CNT_W-1:0] lag_reg;
    logic [HW_W+COL_W-1:0] lag_prod;

    assign lag_prod = {{COL_W{1'b0}}, cl_hh} * {{HW_W{1'b0}}, cl_w};

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            g_w_reg  <= cl_w;
            g_h_reg  <= cl_h;
            g_hw_reg <= cl_hw;
            g_hh_reg <= cl_hh;
            lag_reg  <= CNT_W'(lag_prod) + CNT_W'(cl_hw);
        end
    end

    // input word
    in_word_t item_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            item_reg <= in_data;
    end

    // raster counters
    logic [COL_W-1:0] in_col_reg, out_col_reg;
    logic [ROW_W-1:0] in_row_reg, out_row_reg;
    logic [CNT_W-1:0] in_cnt_reg;
    logic [AW-1:0]    in_addr_reg, out_addr_reg;
    logic             active_reg, done_reg;
    logic             in_col_end, in_row_end, out_col_end, out_last;

    assign in_col_end  = (in_col_reg == COL_W'(g_w_reg - COL_W'(1)));
    assign in_row_end  = ({1'b0, in_row_reg} == DIM_W'(g_h_reg - DIM_W'(1)));
    assign out_col_end = (out_col_reg == COL_W'(g_w_reg - COL_W'(1)));
    assign out_last    = out_col_end &&
                         ({1'b0, out_row_reg} == DIM_W'(g_h_reg - DIM_W'(1)));

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : AW'(a + AW'(1));
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_cnt_reg   <= '0;
            in_addr_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_addr_reg <= '0;
            active_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
                active_reg <= 1'b1;
            if (cmd.write)
            begin
                in_cnt_reg  <= CNT_W'(in_cnt_reg + CNT_W'(1));
                in_addr_reg <= addr_inc(in_addr_reg);
                if (in_col_end)
                begin
                    in_col_reg <= '0;
                    if (in_row_end)
                    begin
                        in_row_reg <= '0;
                        done_reg   <= 1'b1;
                    end
                    else
                        in_row_reg <= ROW_W'(in_row_reg + ROW_W'(1));
                end
                else
                    in_col_reg <= COL_W'(in_col_reg + COL_W'(1));
            end
            if (cmd.emit)
            begin
                if (out_last)
                begin
                    in_col_reg   <= '0;
                    in_row_reg   <= '0;
                    in_cnt_reg   <= '0;
                    in_addr_reg  <= '0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    out_addr_reg <= '0;
                    active_reg   <= 1'b0;
                    done_reg     <= 1'b0;
                end
                else
                begin
                    out_addr_reg <= addr_inc(out_addr_reg);
                    if (out_col_end)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= ROW_W'(out_row_reg + ROW_W'(1));
                    end
                    else
                        out_col_reg <= COL_W'(out_col_reg + COL_W'(1));
                end
            end
        end
    end

    // window geometry
    logic [HW_W-1:0]   dy, dx, dn, dr;
    logic [DIM_W-1:0]  rows_below;
    logic [COL_W-1:0]  cols_right;
    logic [SPAN_W-1:0] nr, nc;
    logic [AW-1:0]     off, base;
    logic [HW_W+COL_W-1:0] off_prod;

    always_comb
    begin
        dy = (out_row_reg > ROW_W'(g_hh_reg)) ? g_hh_reg : HW_W'(out_row_reg);
        dx = (out_col_reg > COL_W'(g_hw_reg)) ? g_hw_reg : HW_W'(out_col_reg);
        rows_below = DIM_W'(g_h_reg - DIM_W'(1) - {1'b0, out_row_reg});
        cols_right = COL_W'(g_w_reg - COL_W'(1) - out_col_reg);
        dn = (rows_below > DIM_W'(g_hh_reg)) ? g_hh_reg : HW_W'(rows_below);
        dr = (cols_right > COL_W'(g_hw_reg)) ? g_hw_reg : HW_W'(cols_right);
        nr = SPAN_W'(SPAN_W'(dy) + SPAN_W'(dn) + SPAN_W'(1));
        nc = SPAN_W'(SPAN_W'(dx) + SPAN_W'(dr) + SPAN_W'(1));
        off_prod = {{COL_W{1'b0}}, dy} * {{HW_W{1'b0}}, g_w_reg};
        off  = AW'(AW'(off_prod) + AW'(dx));
        base = (out_addr_reg >= off) ? AW'(out_addr_reg - off)
                                     : AW'(out_addr_reg + AW'(DEPTH) - off);
    end

    // window gather
    logic [SPAN_W-1:0] nr_reg, nc_reg, rr_reg, cc_reg;
    logic [AW-1:0]     row_base_reg, cur_addr_reg;
    logic [AW:0]       row_sum;
    logic [AW-1:0]     row_next;
    logic              rd_pend_reg;
    logic [COLOR_W-1:0] rd_data;
    logic              cc_end;

    assign cc_end   = (cc_reg == SPAN_W'(nc_reg - SPAN_W'(1)));
    assign row_sum  = {1'b0, row_base_reg} + (AW+1)'(g_w_reg);
    assign row_next = (row_sum >= (AW+1)'(DEPTH)) ? AW'(row_sum - (AW+1)'(DEPTH))
                                                  : AW'(row_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_pend_reg <= 1'b0;
        else
            rd_pend_reg <= cmd.load_issue;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.win_init)
        begin
            nr_reg       <= nr;
            nc_reg       <= nc;
            rr_reg       <= '0;
            cc_reg       <= '0;
            row_base_reg <= base;
            cur_addr_reg <= base;
        end
        else if (cmd.load_issue)
        begin
            if (cc_end)
            begin
                cc_reg       <= '0;
                rr_reg       <= SPAN_W'(rr_reg + SPAN_W'(1));
                row_base_reg <= row_next;
                cur_addr_reg <= row_next;
            end
            else
            begin
                cc_reg       <= SPAN_W'(cc_reg + SPAN_W'(1));
                cur_addr_reg <= addr_inc(cur_addr_reg);
            end
        end
    end

    wmf_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (in_addr_reg),
        .wdata (item_reg.pixel_color),
        .raddr (cur_addr_reg),
        .rdata (rd_data)
    );

    // window buffer and mode count
    logic [COLOR_W-1:0] win_reg [WIN];
    logic [WIN-1:0]     vld_reg;
    logic [WIN_IW-1:0]  ci_reg;
    logic [COLOR_W-1:0] best_reg;
    logic [WIN_CW-1:0]  best_cnt_reg;
    logic [WIN-1:0]     match;
    logic [WIN_CW-1:0]  cnt;

    always_comb
    begin
        for (int j = 0; j < WIN; j++)
            match[j] = vld_reg[j] && (win_reg[j] == win_reg[0]);
        cnt = WIN_CW'($countones(match));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.win_init)
        begin
            vld_reg      <= '0;
            ci_reg       <= '0;
            best_reg     <= '0;
            best_cnt_reg <= '0;
        end
        else if (rd_pend_reg)
        begin
            for (int j = 0; j < WIN - 1; j++)
            begin
                win_reg[j] <= win_reg[j+1];
                vld_reg[j] <= vld_reg[j+1];
            end
            win_reg[WIN-1] <= rd_data;
            vld_reg[WIN-1] <= 1'b1;
        end
        else if (cmd.count_step)
        begin
            for (int j = 0; j < WIN - 1; j++)
            begin
                win_reg[j] <= win_reg[j+1];
                vld_reg[j] <= vld_reg[j+1];
            end
            win_reg[WIN-1] <= win_reg[0];
            vld_reg[WIN-1] <= vld_reg[0];
            ci_reg         <= WIN_IW'(ci_reg + WIN_IW'(1));
            if (vld_reg[0] && ((cnt > best_cnt_reg) ||
                ((cnt == best_cnt_reg) && (win_reg[0] < best_reg))))
            begin
                best_reg     <= win_reg[0];
                best_cnt_reg <= cnt;
            end
        end
    end

    // output register
    logic      out_valid_reg;
    out_word_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg.mode_color    <= best_reg;
            out_data_reg.last_of_frame <= out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        sts.is_pixel   = (item_reg.op == OP_PIXEL);
        sts.active     = active_reg;
        sts.done       = done_reg;
        sts.emit_due   = (in_cnt_reg >= lag_reg);
        sts.load_last  = cc_end && (rr_reg == SPAN_W'(nr_reg - SPAN_W'(1)));
        sts.count_last = (ci_reg == WIN_IW'(WIN - 1));
        sts.out_free   = !out_valid_reg || out_ready;
    end

endmodule

/* rtl/windowed_mode_filter_top.sv */
// ----------------------------------------------------------------------------
// windowed_mode_filter_top
// 2-D mode filter over a raster stream of packed RGBA pixels.
// ----------------------------------------------------------------------------
// a word yielding a result (drain, pixel, first pixel of a frame) has its
// clipped window read from the line store, one read per cycle, and then
// counted for its mode
// next word is taken once the result sits in the output register
// reset clears counters and frame flags, loads register defaults; line store
// is not cleared
module windowed_mode_filter_top
    import wmf_pkg::*;
#(
    parameter int MAX_HALF_WINDOW = 3,
    parameter int MAX_IMAGE_WIDTH = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_data
);

    wmf_cmd_t cmd;
    wmf_sts_t sts;

    wmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wmf_datapath #(
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
        .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded over an untaken word");

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word taken while one is in work");

    a_write_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (sts.is_pixel && !sts.done))
        else $error("store write after frame input complete");

endmodule
